// ===== src/fssc_pkg.sv =====
package fssc_pkg;

	// controller states, in the order the result field encodes them
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ASSESS,
		ST_TURN,
		ST_ADJUST,
		ST_SPRAY
	} state_t;

	// stored fire direction
	typedef enum logic [2:0] {
		HD_FRONT,
		HD_LEFT,
		HD_RIGHT,
		HD_REAR,
		HD_NONE
	} head_t;

	// motor and pump commands
	typedef enum logic [2:0] {
		CMD_HALT,
		CMD_LEFT,
		CMD_RIGHT,
		CMD_REVERSE,
		CMD_WATER_ON,
		CMD_WATER_OFF
	} cmd_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_RUN_MODE,
		REG_TOO_CLOSE,
		REG_MIN_SPRAY,
		REG_TARGET,
		REG_MAX_APPROACH,
		REG_SPRAY_TIME,
		REG_TURN_TIMEOUT,
		REG_ADJUST_TIMEOUT
	} reg_t;

	localparam logic [1:0] MODE_OFF  = 2'd0;
	localparam logic [1:0] MODE_AUTO = 2'd1;

	// echo products: echo_us * 343, compared against mm * 2000
	localparam int          X_W          = 25;
	localparam logic [X_W-1:0] MM_SCALE  = 25'd343;
	localparam logic [X_W-1:0] X_PER_MM  = 25'd2000;
	localparam logic [X_W-1:0] X_NEAR    = 25'd40000;   // 20 mm
	localparam logic [15:0] ECHO_MAX_US  = 16'd25000;
	localparam logic [12:0] WIN_MARGIN_MM = 13'd31;     // window edge + 30, strict compare

	localparam logic [9:0]  ASSESS_WAIT_MS = 10'd700;

	// reset values of the registers
	localparam logic [1:0]  RST_RUN_MODE    = MODE_AUTO;
	localparam logic [11:0] RST_TOO_CLOSE   = 12'd100;
	localparam logic [11:0] RST_MIN_SPRAY   = 12'd150;
	localparam logic [11:0] RST_TARGET      = 12'd250;
	localparam logic [11:0] RST_MAX_APPROACH = 12'd400;
	localparam logic [15:0] RST_SPRAY_TIME  = 16'd5000;
	localparam logic [15:0] RST_TURN_TO     = 16'd8000;
	localparam logic [15:0] RST_ADJUST_TO   = 16'd7000;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;

	// classified tick: flame directions and distance bands
	typedef struct packed {
		logic front;
		logic left;
		logic right;
		logic rear;
		logic lt_close;
		logic gt_far;
		logic lt_min;
	} cls_t;

	function automatic logic [X_W-1:0] mm_to_x(input logic [12:0] mm);
		return X_W'(mm) * X_PER_MM;
	endfunction

endpackage

// ===== src/fssc_front.sv =====
module fssc_front #(
	parameter int TW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [5:0]        flame_bits,
	input  logic [15:0]       echo_us,
	input  logic [31:0]       now_ms,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output logic              push_valid,
	input  logic              push_ready,
	output fssc_pkg::cls_t    push_cls,
	output logic [TW-1:0]     push_ms
);
	import fssc_pkg::*;

	logic            v_s1;
	logic            front_s1, left_s1, right_s1, rear_s1;
	logic            far_s1;
	logic [X_W-1:0]  x_s1;
	logic [TW-1:0]   now_s1;

	logic [X_W-1:0]  close_x_q, min_x_q, win_x_q, max_x_q;
	logic            far_w;

	// scaled distance thresholds, rewritten on register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_x_q <= mm_to_x({1'b0, RST_TOO_CLOSE});
			min_x_q   <= mm_to_x({1'b0, RST_MIN_SPRAY});
			win_x_q   <= mm_to_x({1'b0, RST_TARGET} + WIN_MARGIN_MM);
			max_x_q   <= mm_to_x({1'b0, RST_MAX_APPROACH} + 13'd1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOO_CLOSE:    close_x_q <= mm_to_x({1'b0, cfg_data[11:0]});
				REG_MIN_SPRAY:    min_x_q   <= mm_to_x({1'b0, cfg_data[11:0]});
				REG_TARGET:       win_x_q   <= mm_to_x({1'b0, cfg_data[11:0]} + WIN_MARGIN_MM);
				REG_MAX_APPROACH: max_x_q   <= mm_to_x({1'b0, cfg_data[11:0]} + 13'd1);
				default: ;
			endcase
		end
	end

	// input stage: take a word whenever the stage is empty or drains
	assign in_ready = !v_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	// decode flame sensors and scale the echo
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			front_s1 <= flame_bits[0] | flame_bits[1];
			left_s1  <= flame_bits[2] | (flame_bits[0] & ~flame_bits[1] & ~flame_bits[3]);
			right_s1 <= flame_bits[3] | (flame_bits[1] & ~flame_bits[0] & ~flame_bits[2]);
			rear_s1  <= flame_bits[4] | flame_bits[5];
			far_s1   <= (echo_us == 16'd0) || (echo_us >= ECHO_MAX_US);
			x_s1     <= X_W'(echo_us) * MM_SCALE;
			now_s1   <= TW'(now_ms);
		end
	end

	// band the distance; a far reading lies above every threshold
	assign far_w = far_s1 || (x_s1 < X_NEAR);

	always_comb begin
		push_cls.front    = front_s1;
		push_cls.left     = left_s1;
		push_cls.right    = right_s1;
		push_cls.rear     = rear_s1;
		push_cls.lt_close = !far_w && (x_s1 < close_x_q);
		push_cls.lt_min   = !far_w && (x_s1 < min_x_q);
		push_cls.gt_far   = far_w || (x_s1 >= max_x_q) || (x_s1 >= win_x_q);
	end

	assign push_valid = v_s1;
	assign push_ms    = now_s1;

endmodule

// ===== src/fssc_queue.sv =====
module fssc_queue #(
	parameter int TW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  fssc_pkg::cls_t    push_cls,
	input  logic [TW-1:0]     push_ms,
	output logic              pop_valid,
	input  logic              pop,
	output fssc_pkg::cls_t    pop_cls,
	output logic [TW-1:0]     pop_ms
);
	import fssc_pkg::*;

	cls_t              cls_mem [QDEPTH];
	logic [TW-1:0]     ms_mem  [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign push_ready = (count_q != (QPTR_W+1)'(QDEPTH));
	assign pop_valid  = (count_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;

	// store a word at the tail
	always_ff @(posedge clk) begin
		if (do_push) begin
			cls_mem[wr_ptr_q] <= push_cls;
			ms_mem[wr_ptr_q]  <= push_ms;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)      count_q <= count_q + (QPTR_W+1)'(1);
			else if (do_pop && !do_push) count_q <= count_q - (QPTR_W+1)'(1);
		end
	end

	assign pop_cls = cls_mem[rd_ptr_q];
	assign pop_ms  = ms_mem[rd_ptr_q];

endmodule

// ===== src/fssc_back.sv =====
module fssc_back #(
	parameter int TW = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	output logic              q_pop,
	input  fssc_pkg::cls_t    q_cls,
	input  logic [TW-1:0]     q_ms,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        command,
	output logic              is_last,
	output logic [2:0]        fsm_now,
	output logic [2:0]        heading
);
	import fssc_pkg::*;

	logic [1:0]    mode_q;
	logic [15:0]   spray_ms_q, turn_to_q, adjust_to_q;
	state_t        fsm_q, fsm_n;
	head_t         head_q, head_n;
	logic [TW-1:0] entry_q;
	logic          entry_upd;

	logic [TW-1:0] elapsed, limit;
	logic          over;
	logic          any_flame;
	cmd_t          c0, c1, c2;
	logic [1:0]    cnt;
	logic          step_go, pk_load, pk_free;

	logic          pk_valid_q;
	cmd_t          pk_cmd_q [3];
	logic [1:0]    pk_cnt_q, idx_q;
	state_t        pk_state_q;
	head_t         pk_head_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= RST_RUN_MODE;
			spray_ms_q  <= RST_SPRAY_TIME;
			turn_to_q   <= RST_TURN_TO;
			adjust_to_q <= RST_ADJUST_TO;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RUN_MODE:       mode_q      <= cfg_data[1:0];
				REG_SPRAY_TIME:     spray_ms_q  <= cfg_data;
				REG_TURN_TIMEOUT:   turn_to_q   <= cfg_data;
				REG_ADJUST_TIMEOUT: adjust_to_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// timer: wrapping time in state against the limit of this state
	always_comb begin
		case (fsm_q)
			ST_ASSESS: limit = TW'(ASSESS_WAIT_MS);
			ST_TURN:   limit = TW'(turn_to_q);
			ST_ADJUST: limit = TW'(adjust_to_q);
			ST_SPRAY:  limit = TW'(spray_ms_q);
			default:   limit = '0;
		endcase
	end

	assign elapsed   = q_ms - entry_q;
	assign over      = elapsed > limit;
	assign any_flame = q_cls.front | q_cls.left | q_cls.right | q_cls.rear;

	// next state, entry time and heading
	always_comb begin
		fsm_n     = fsm_q;
		head_n    = head_q;
		entry_upd = 1'b0;
		if (mode_q == MODE_AUTO) begin
			case (fsm_q)
				ST_IDLE: begin
					if (any_flame) begin
						fsm_n     = ST_ASSESS;
						entry_upd = 1'b1;
					end
				end
				ST_ASSESS: begin
					if (over) begin
						if (q_cls.front)
							head_n = HD_FRONT;
						else if (q_cls.left && !q_cls.right && !q_cls.rear)
							head_n = HD_LEFT;
						else if (q_cls.right && !q_cls.left && !q_cls.rear)
							head_n = HD_RIGHT;
						else if (q_cls.rear && !q_cls.left && !q_cls.right)
							head_n = HD_REAR;
						else if (q_cls.left && q_cls.right && !q_cls.rear)
							head_n = HD_LEFT;
						else
							head_n = HD_NONE;
						if (head_n == HD_FRONT)     fsm_n = ST_ADJUST;
						else if (head_n != HD_NONE) fsm_n = ST_TURN;
						else                        fsm_n = ST_IDLE;
						entry_upd = 1'b1;
					end
				end
				ST_TURN: begin
					if (q_cls.front) begin
						fsm_n     = ST_ADJUST;
						entry_upd = 1'b1;
					end else if (over) begin
						fsm_n = ST_IDLE;
					end else if (!(head_q inside {HD_LEFT, HD_REAR, HD_RIGHT})) begin
						fsm_n     = ST_ASSESS;
						entry_upd = 1'b1;
					end
				end
				ST_ADJUST: begin
					if (!q_cls.front) begin
						fsm_n     = ST_ASSESS;
						entry_upd = 1'b1;
					end else if (q_cls.gt_far && !q_cls.lt_close) begin
						fsm_n = ST_SPRAY;
					end else if (q_cls.lt_close || q_cls.lt_min) begin
						if (over) begin
							fsm_n     = ST_SPRAY;
							entry_upd = 1'b1;
						end
					end else begin
						fsm_n     = ST_SPRAY;
						entry_upd = 1'b1;
					end
				end
				ST_SPRAY: begin
					if (!q_cls.front) begin
						fsm_n = ST_IDLE;
					end else if (over) begin
						fsm_n     = ST_ASSESS;
						entry_upd = 1'b1;
					end
				end
				default: fsm_n = ST_IDLE;
			endcase
		end
	end

	// command run of this tick
	always_comb begin
		c0  = CMD_HALT;
		c1  = CMD_HALT;
		c2  = CMD_HALT;
		cnt = 2'd0;
		if (mode_q == MODE_OFF) begin
			c1  = CMD_WATER_OFF;
			cnt = 2'd2;
		end else if (mode_q == MODE_AUTO) begin
			case (fsm_q)
				ST_IDLE: begin
					c0  = CMD_WATER_OFF;
					cnt = any_flame ? 2'd2 : 2'd1;
				end
				ST_ASSESS: begin
					c1  = CMD_WATER_OFF;
					cnt = 2'd2;
				end
				ST_TURN: begin
					c0  = CMD_WATER_OFF;
					cnt = 2'd2;
					if (!q_cls.front && !over) begin
						if (head_q inside {HD_LEFT, HD_REAR}) c1 = CMD_LEFT;
						else if (head_q == HD_RIGHT)          c1 = CMD_RIGHT;
					end
				end
				ST_ADJUST: begin
					c0 = CMD_WATER_OFF;
					if (!q_cls.front) begin
						cnt = 2'd2;
					end else if (q_cls.lt_close ||
					             (!q_cls.gt_far && q_cls.lt_min)) begin
						c1  = CMD_REVERSE;
						cnt = over ? 2'd3 : 2'd2;
					end else if (q_cls.gt_far) begin
						cnt = 2'd1;
					end else begin
						cnt = 2'd2;
					end
				end
				ST_SPRAY: begin
					cnt = 2'd2;
					if (!q_cls.front) begin
						c1 = CMD_WATER_OFF;
					end else begin
						c1 = CMD_WATER_ON;
						if (over) begin
							c2  = CMD_WATER_OFF;
							cnt = 2'd3;
						end
					end
				end
				default: cnt = 2'd0;
			endcase
		end
	end

	// run a tick once its commands have room in the output packet; a tick with no commands does not wait
	assign is_last = (idx_q == pk_cnt_q - 2'd1);
	assign pk_free = !pk_valid_q || (out_ready && is_last);
	assign step_go = q_valid && ((cnt == 2'd0) || pk_free);
	assign pk_load = step_go && (cnt != 2'd0);
	assign q_pop   = step_go;

	// controller state; a mode write drops back to idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q   <= ST_IDLE;
			head_q  <= HD_FRONT;
			entry_q <= '0;
		end else if (cfg_we && cfg_index == REG_RUN_MODE) begin
			fsm_q <= ST_IDLE;
		end else if (step_go) begin
			fsm_q  <= fsm_n;
			head_q <= head_n;
			if (entry_upd) entry_q <= q_ms;
		end
	end

	// output packet: hold commands, advance one word per handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pk_valid_q <= 1'b0;
			idx_q      <= 2'd0;
		end else if (pk_load) begin
			pk_valid_q <= 1'b1;
			idx_q      <= 2'd0;
		end else if (pk_valid_q && out_ready) begin
			if (is_last) pk_valid_q <= 1'b0;
			else         idx_q      <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pk_load) begin
			pk_cmd_q[0] <= c0;
			pk_cmd_q[1] <= c1;
			pk_cmd_q[2] <= c2;
			pk_cnt_q    <= cnt;
			pk_state_q  <= fsm_n;
			pk_head_q   <= head_n;
		end
	end

	// select the current word
	always_comb begin
		case (idx_q)
			2'd0:    command = pk_cmd_q[0];
			2'd1:    command = pk_cmd_q[1];
			default: command = pk_cmd_q[2];
		endcase
	end

	assign out_valid = pk_valid_q;
	assign fsm_now   = pk_state_q;
	assign heading   = pk_head_q;

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		pk_valid_q |-> (idx_q < pk_cnt_q))
		else $error("word index beyond command count");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !is_last) |=>
			(pk_valid_q && idx_q == $past(idx_q) + 2'd1))
		else $error("packet did not advance to next word");

	a_mode_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == REG_RUN_MODE) |=> (fsm_q == ST_IDLE))
		else $error("mode write did not return controller to idle");

endmodule

// ===== src/flame_seek_spray_controller.sv =====
// Flame-seek and spray controller. Each input word is one control tick (flame
// sensor bits, ultrasonic echo width, millisecond timestamp); the block runs a
// five-state seek/assess/turn/adjust/spray controller and answers each tick
// with zero to three command words, the last one flagged by is_last, all
// carrying the state and heading after the tick. The front stage takes one
// tick per cycle while the queue has room, decodes flame directions and
// bands the echo distance, and parks the result in a four-entry queue. The
// back end executes one tick per cycle while the output allows it, but holds
// a tick with commands until the single output packet register is free, that
// is, until the last word of the previous packet is taken; a tick with no
// commands does not wait. Register writes take effect at once and are meant
// for an idle block; a run_mode write returns the controller to idle.
module flame_seek_spray_controller #(
	parameter int TIME_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [5:0]  flame_bits,
	input  logic [15:0] echo_us,
	input  logic [31:0] now_ms,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  command,
	output logic        is_last,
	output logic [2:0]  fsm_now,
	output logic [2:0]  heading
);
	import fssc_pkg::*;

	logic                  push_valid, push_ready;
	cls_t                  push_cls, pop_cls;
	logic [TIME_WIDTH-1:0] push_ms, pop_ms;
	logic                  pop_valid, pop;

	fssc_front #(.TW(TIME_WIDTH)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.flame_bits (flame_bits),
		.echo_us    (echo_us),
		.now_ms     (now_ms),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cls   (push_cls),
		.push_ms    (push_ms)
	);

	fssc_queue #(.TW(TIME_WIDTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cls   (push_cls),
		.push_ms    (push_ms),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.pop_cls    (pop_cls),
		.pop_ms     (pop_ms)
	);

	fssc_back #(.TW(TIME_WIDTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (pop_valid),
		.q_pop     (pop),
		.q_cls     (pop_cls),
		.q_ms      (pop_ms),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.command   (command),
		.is_last   (is_last),
		.fsm_now   (fsm_now),
		.heading   (heading)
	);

endmodule
